>>> hdl/dsd_pkg.sv
// Shared types, constants and helpers for the disk seek distance unit.
`timescale 1ns / 1ps

package dsd_pkg;

  localparam int unsigned MaxRequests = 1024;
  localparam int unsigned IdxW        = $clog2(MaxRequests);
  localparam int unsigned CntW        = $clog2(MaxRequests + 1);
  localparam int unsigned CylW        = 16;
  localparam int unsigned SumW        = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned PolicyW     = 3;
  localparam int unsigned RamW        = CylW + 1;

  // Policy codes
  localparam logic [PolicyW-1:0] PolFcfs  = 3'd0;
  localparam logic [PolicyW-1:0] PolSstf  = 3'd1;
  localparam logic [PolicyW-1:0] PolScan  = 3'd2;
  localparam logic [PolicyW-1:0] PolCscan = 3'd3;
  localparam logic [PolicyW-1:0] PolLook  = 3'd4;
  localparam logic [PolicyW-1:0] PolClook = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPolicy    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSweepDir  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStartHead = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgLastCyl   = 2'd3;

  localparam logic [CylW-1:0] LastCylReset = 16'd4999;

  typedef enum logic [4:0] {
    StLoad = 5'b00001,
    StScan = 5'b00010,
    StMark = 5'b00100,
    StComb = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [CylW-1:0] request_cylinder;
    logic            last_request;
  } in_item_t;

  typedef struct packed {
    logic [SumW-1:0] total_movement;
    logic [CntW-1:0] request_count;
    logic            overflow;
  } out_item_t;

  function automatic logic [CylW-1:0] abs_diff(logic [CylW-1:0] a, logic [CylW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> hdl/disk_seek_distance_unit.sv
// Top level of the disk seek distance unit: request store, job walker and result register.
`timescale 1ns / 1ps

// Requests load into a 1024-entry store at one item per cycle while the unit
// is in its load phase. The item with last_request set closes the job: the
// unit then stops taking items, walks the store through its one read port
// and holds the result until it is taken, after which loading resumes.
// FCFS and the four sweep policies need one pass over the store (the sweep
// policies then add edge and side moves, built from the minimum and maximum
// of each side); SSTF needs one pass per served request plus a final empty
// pass, one read at a time through the single read port.
// Requests beyond 1024 are dropped and flag overflow. Each stored request
// carries its SSTF served bit in the same memory word; storing a request
// clears it, so no clearing pass is needed after reset.

module disk_seek_distance_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  dsd_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output dsd_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dsd_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CylW = dsd_pkg::CylW;
  localparam int unsigned SumW = dsd_pkg::SumW;
  localparam int unsigned CntW = dsd_pkg::CntW;
  localparam int unsigned IdxW = dsd_pkg::IdxW;

  dsd_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [dsd_pkg::PolicyW-1:0] policy_q, policy_d;
  logic                        sweep_q, sweep_d;
  logic [CylW-1:0]             start_q, start_d;
  logic [CylW-1:0]             lastcyl_q, lastcyl_d;

  // Job state
  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic [CylW-1:0] head_q, head_d;
  logic [SumW-1:0] sum_q, sum_d;

  // Walk state
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            pv_q, pv_d;
  logic [IdxW-1:0] pidx_q, pidx_d;
  logic            found_q, found_d;
  logic [CylW-1:0] best_d_q, best_d_d;
  logic [CylW-1:0] best_c_q, best_c_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;

  // Side extremes for the sweep policies
  logic            has_lo_q, has_lo_d, has_hi_q, has_hi_d;
  logic [CylW-1:0] min_lo_q, min_lo_d, max_lo_q, max_lo_d;
  logic [CylW-1:0] min_hi_q, min_hi_d, max_hi_q, max_hi_d;
  logic [2:0]      step_q, step_d;

  // Memory port
  logic                       ram_we;
  logic [IdxW-1:0]            ram_waddr;
  logic [dsd_pkg::RamW-1:0]   ram_wdata;
  logic [dsd_pkg::RamW-1:0]   ram_rdata;
  logic                       rd_en;

  logic            in_acc, out_acc, cfg_acc;
  logic            is_sstf, is_sweep, is_scan, is_cscan, is_look, rev_side;
  logic [CylW-1:0] rd_cyl, rd_dist;
  logic            rd_served;
  logic            mv_en;
  logic [CylW-1:0] mv_tgt;

  dsd_ram #(
    .Width (dsd_pkg::RamW),
    .Depth (dsd_pkg::MaxRequests)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == dsd_pkg::StLoad);
  assign out_valid_o = (state_q == dsd_pkg::StOut);
  assign cfg_ready_o = 1'b1;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign cfg_acc = cfg_valid_i;

  assign out_data_o.total_movement = sum_q;
  assign out_data_o.request_count  = count_q;
  assign out_data_o.overflow       = drop_q;

  assign is_sstf  = (policy_q == dsd_pkg::PolSstf);
  assign is_scan  = (policy_q == dsd_pkg::PolScan);
  assign is_cscan = (policy_q == dsd_pkg::PolCscan);
  assign is_look  = (policy_q == dsd_pkg::PolLook);
  assign is_sweep = is_scan || is_cscan || is_look || (policy_q == dsd_pkg::PolClook);
  // SCAN and LOOK reverse through the second side; the circular ones wrap.
  assign rev_side = is_scan || is_look;

  assign rd_en     = (state_q == dsd_pkg::StScan) && (rd_idx_q != count_q);
  assign rd_cyl    = ram_rdata[CylW-1:0];
  assign rd_served = ram_rdata[CylW];
  assign rd_dist   = dsd_pkg::abs_diff(rd_cyl, head_q);

  // Move list of the sweep policies, one move per step
  always_comb begin
    mv_en  = 1'b0;
    mv_tgt = '0;
    if (sweep_q) begin
      case (step_q)
        3'd0: begin mv_en = has_hi_q; mv_tgt = min_hi_q; end
        3'd1: begin mv_en = has_hi_q; mv_tgt = max_hi_q; end
        3'd2: begin mv_en = is_scan || is_cscan; mv_tgt = lastcyl_q; end
        3'd4: begin mv_en = has_lo_q; mv_tgt = rev_side ? max_lo_q : min_lo_q; end
        3'd5: begin mv_en = has_lo_q; mv_tgt = rev_side ? min_lo_q : max_lo_q; end
        default: begin mv_en = 1'b0; mv_tgt = '0; end
      endcase
    end else begin
      case (step_q)
        3'd0: begin mv_en = has_lo_q; mv_tgt = max_lo_q; end
        3'd1: begin mv_en = has_lo_q; mv_tgt = min_lo_q; end
        3'd2: begin mv_en = is_scan || is_cscan; mv_tgt = '0; end
        3'd4: begin mv_en = has_hi_q; mv_tgt = rev_side ? min_hi_q : max_hi_q; end
        3'd5: begin mv_en = has_hi_q; mv_tgt = rev_side ? max_hi_q : min_hi_q; end
        default: begin mv_en = 1'b0; mv_tgt = '0; end
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    policy_d   = policy_q;
    sweep_d    = sweep_q;
    start_d    = start_q;
    lastcyl_d  = lastcyl_q;
    count_d    = count_q;
    drop_d     = drop_q;
    head_d     = head_q;
    sum_d      = sum_q;
    rd_idx_d   = rd_idx_q;
    pv_d       = rd_en;
    pidx_d     = rd_idx_q[IdxW-1:0];
    found_d    = found_q;
    best_d_d   = best_d_q;
    best_c_d   = best_c_q;
    best_idx_d = best_idx_q;
    has_lo_d   = has_lo_q;
    has_hi_d   = has_hi_q;
    min_lo_d   = min_lo_q;
    max_lo_d   = max_lo_q;
    min_hi_d   = min_hi_q;
    max_hi_d   = max_hi_q;
    step_d     = step_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[IdxW-1:0];
    ram_wdata  = {1'b0, in_data_i.request_cylinder};

    if (cfg_acc) begin
      case (cfg_index_i)
        dsd_pkg::CfgPolicy:    policy_d  = cfg_data_i[dsd_pkg::PolicyW-1:0];
        dsd_pkg::CfgSweepDir:  sweep_d   = cfg_data_i[0];
        dsd_pkg::CfgStartHead: start_d   = cfg_data_i[CylW-1:0];
        dsd_pkg::CfgLastCyl:   lastcyl_d = cfg_data_i[CylW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      dsd_pkg::StLoad: begin
        if (in_acc) begin
          // Store while there is room, otherwise drop and flag
          if (count_q != CntW'(dsd_pkg::MaxRequests)) begin
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.last_request) begin
            state_d  = dsd_pkg::StScan;
            head_d   = start_q;
            sum_d    = '0;
            rd_idx_d = '0;
            found_d  = 1'b0;
            has_lo_d = 1'b0;
            has_hi_d = 1'b0;
            step_d   = '0;
          end
        end
      end
      dsd_pkg::StScan: begin
        if (rd_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (pv_q) begin
          if (is_sstf) begin
            // Strict compare keeps the earliest request on a tie
            if (!rd_served && (!found_q || (rd_dist < best_d_q))) begin
              found_d    = 1'b1;
              best_d_d   = rd_dist;
              best_c_d   = rd_cyl;
              best_idx_d = pidx_q;
            end
          end else if (is_sweep) begin
            if (rd_cyl <= head_q) begin
              has_lo_d = 1'b1;
              if (!has_lo_q || (rd_cyl < min_lo_q)) min_lo_d = rd_cyl;
              if (!has_lo_q || (rd_cyl > max_lo_q)) max_lo_d = rd_cyl;
            end else begin
              has_hi_d = 1'b1;
              if (!has_hi_q || (rd_cyl < min_hi_q)) min_hi_d = rd_cyl;
              if (!has_hi_q || (rd_cyl > max_hi_q)) max_hi_d = rd_cyl;
            end
          end else begin
            sum_d  = sum_q + SumW'(rd_dist);
            head_d = rd_cyl;
          end
        end else if (!rd_en) begin
          // Pass over: last read data has been consumed
          if (is_sstf) begin
            state_d = found_q ? dsd_pkg::StMark : dsd_pkg::StOut;
          end else if (is_sweep) begin
            state_d = dsd_pkg::StComb;
          end else begin
            state_d = dsd_pkg::StOut;
          end
        end
      end
      dsd_pkg::StMark: begin
        // Serve the nearest request and mark it in the store
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        ram_wdata = {1'b1, best_c_q};
        sum_d     = sum_q + SumW'(best_d_q);
        head_d    = best_c_q;
        rd_idx_d  = '0;
        found_d   = 1'b0;
        state_d   = dsd_pkg::StScan;
      end
      dsd_pkg::StComb: begin
        if (step_q == 3'd3) begin
          if (is_cscan) begin
            // Full return across the disk
            sum_d  = sum_q + SumW'(lastcyl_q);
            head_d = sweep_q ? '0 : lastcyl_q;
          end
        end else if (mv_en) begin
          sum_d  = sum_q + SumW'(dsd_pkg::abs_diff(mv_tgt, head_q));
          head_d = mv_tgt;
        end
        step_d = step_q + 1'b1;
        if (step_q == 3'd5) begin
          state_d = dsd_pkg::StOut;
        end
      end
      dsd_pkg::StOut: begin
        if (out_acc) begin
          count_d = '0;
          drop_d  = 1'b0;
          state_d = dsd_pkg::StLoad;
        end
      end
      default: state_d = dsd_pkg::StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dsd_pkg::StLoad;
      policy_q  <= dsd_pkg::PolFcfs;
      sweep_q   <= 1'b0;
      start_q   <= '0;
      lastcyl_q <= dsd_pkg::LastCylReset;
      count_q   <= '0;
      drop_q    <= 1'b0;
      head_q    <= '0;
      sum_q     <= '0;
      rd_idx_q  <= '0;
      pv_q      <= 1'b0;
      found_q   <= 1'b0;
      has_lo_q  <= 1'b0;
      has_hi_q  <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      policy_q  <= policy_d;
      sweep_q   <= sweep_d;
      start_q   <= start_d;
      lastcyl_q <= lastcyl_d;
      count_q   <= count_d;
      drop_q    <= drop_d;
      head_q    <= head_d;
      sum_q     <= sum_d;
      rd_idx_q  <= rd_idx_d;
      pv_q      <= pv_d;
      found_q   <= found_d;
      has_lo_q  <= has_lo_d;
      has_hi_q  <= has_hi_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    best_d_q   <= best_d_d;
    best_c_q   <= best_c_d;
    best_idx_q <= best_idx_d;
    min_lo_q   <= min_lo_d;
    max_lo_q   <= max_lo_d;
    min_hi_q   <= min_hi_d;
    max_hi_q   <= max_hi_d;
  end

endmodule

>>> hdl/dsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dsd_checker.sv
// Port-level checks for the disk seek distance unit, bound to the top level.
`timescale 1ns / 1ps

module dsd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input dsd_pkg::out_item_t out_data_o
);

  // A held result keeps its value until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Loading and result delivery never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  // A taken result reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o)
    else $error("input not reopened after result");

  // Every job holds at least one request and never more than capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.request_count != '0) &&
      (out_data_o.request_count <= dsd_pkg::CntW'(dsd_pkg::MaxRequests)))
    else $error("request count out of range");

endmodule

bind disk_seek_distance_unit dsd_checker u_dsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> bench/tb_disk_seek_distance_unit.sv
// Testbench for the disk seek distance unit: directed table plus random jobs, checked by a predictor.
`timescale 1ns / 1ps

module tb_disk_seek_distance_unit;

  localparam int unsigned CycleLimit = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dsd_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dsd_pkg::out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [dsd_pkg::CfgIdxW-1:0] cfg_index_i = dsd_pkg::CfgPolicy;
  logic [dsd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  disk_seek_distance_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Predictor copy of the registers and the job being loaded
  logic [dsd_pkg::PolicyW-1:0] pol_q = dsd_pkg::PolFcfs;
  logic sweep_up_q = 1'b0;
  logic [dsd_pkg::CylW-1:0] start_q = '0;
  logic [dsd_pkg::CylW-1:0] edge_q = dsd_pkg::LastCylReset;
  logic [dsd_pkg::CylW-1:0] job_cyl[$];
  logic job_dropped = 1'b0;

  dsd_pkg::out_item_t pending_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle = 0;
  int unsigned receiver_idle = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Head travel for the stored job under the current policy
  function automatic logic [dsd_pkg::SumW-1:0] seek_travel();
    logic [dsd_pkg::CylW-1:0] srt[$];
    logic done[$];
    longint head, sum, bd, d;
    int lo_n, n, best;
    n = job_cyl.size();
    head = start_q;
    sum = 0;
    if (pol_q == dsd_pkg::PolSstf) begin
      for (int i = 0; i < n; i++) done.push_back(1'b0);
      for (int k = 0; k < n; k++) begin
        best = -1;
        bd = 0;
        for (int i = 0; i < n; i++) begin
          if (done[i]) continue;
          d = (job_cyl[i] > head) ? job_cyl[i] - head : head - job_cyl[i];
          if (best < 0 || d < bd) begin
            best = i;
            bd = d;
          end
        end
        done[best] = 1'b1;
        sum += bd;
        head = job_cyl[best];
      end
    end else if (pol_q >= dsd_pkg::PolScan && pol_q <= dsd_pkg::PolClook) begin
      srt = job_cyl;
      srt.sort();
      lo_n = 0;
      while (lo_n < n && srt[lo_n] <= head) lo_n++;
      if (sweep_up_q) begin
        for (int i = lo_n; i < n; i++) begin
          sum += srt[i] - head; head = srt[i];
        end
        if (pol_q == dsd_pkg::PolScan || pol_q == dsd_pkg::PolCscan) begin
          sum += (edge_q > head) ? edge_q - head : head - edge_q; head = edge_q;
        end
        if (pol_q == dsd_pkg::PolCscan) begin
          sum += edge_q; head = 0;
        end
        if (pol_q == dsd_pkg::PolScan || pol_q == dsd_pkg::PolLook) begin
          for (int i = lo_n - 1; i >= 0; i--) begin
            sum += (srt[i] > head) ? srt[i] - head : head - srt[i]; head = srt[i];
          end
        end else begin
          for (int i = 0; i < lo_n; i++) begin
            sum += (srt[i] > head) ? srt[i] - head : head - srt[i]; head = srt[i];
          end
        end
      end else begin
        for (int i = lo_n - 1; i >= 0; i--) begin
          sum += head - srt[i]; head = srt[i];
        end
        if (pol_q == dsd_pkg::PolScan || pol_q == dsd_pkg::PolCscan) begin
          sum += head; head = 0;
        end
        if (pol_q == dsd_pkg::PolCscan) begin
          sum += edge_q; head = edge_q;
        end
        if (pol_q == dsd_pkg::PolScan || pol_q == dsd_pkg::PolLook) begin
          for (int i = lo_n; i < n; i++) begin
            sum += (srt[i] > head) ? srt[i] - head : head - srt[i]; head = srt[i];
          end
        end else begin
          for (int i = n - 1; i >= lo_n; i--) begin
            sum += (srt[i] > head) ? srt[i] - head : head - srt[i]; head = srt[i];
          end
        end
      end
    end else begin
      // FCFS, and the unused codes that fall back to it
      for (int i = 0; i < n; i++) begin
        sum += (job_cyl[i] > head) ? job_cyl[i] - head : head - job_cyl[i];
        head = job_cyl[i];
      end
    end
    return sum[dsd_pkg::SumW-1:0];
  endfunction

  // Advance the predictor on one accepted request
  task automatic predict_request(input dsd_pkg::in_item_t it);
    dsd_pkg::out_item_t r;
    if (job_cyl.size() < dsd_pkg::MaxRequests) job_cyl.push_back(it.request_cylinder);
    else job_dropped = 1'b1;
    if (it.last_request) begin
      r.total_movement = seek_travel();
      r.request_count = dsd_pkg::CntW'(job_cyl.size());
      r.overflow = job_dropped;
      pending_q.push_back(r);
      job_cyl.delete();
      job_dropped = 1'b0;
    end
  endtask

  // Sample both handshakes at the rising edge; check results against the oldest prediction
  always @(posedge clk_i) begin
    dsd_pkg::out_item_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
    end else begin
      if (rst_ni && in_valid_i && in_ready_o) predict_request(in_data_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_q.pop_front();
          if (out_data_o.total_movement !== want.total_movement)
            report_mismatch("total_movement", out_data_o.total_movement, want.total_movement);
          if (out_data_o.request_count !== want.request_count)
            report_mismatch("request_count", out_data_o.request_count, want.request_count);
          if (out_data_o.overflow !== want.overflow)
            report_mismatch("overflow", out_data_o.overflow, want.overflow);
        end
      end
    end
  end

  // Receiver: drop ready at random at each falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_idle);
  end

  // Drive one register write, hold until it is taken, then drop valid before returning
  task automatic write_reg(input logic [dsd_pkg::CfgIdxW-1:0] idx,
                           input logic [dsd_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      dsd_pkg::CfgPolicy: pol_q = val[dsd_pkg::PolicyW-1:0];
      dsd_pkg::CfgSweepDir: sweep_up_q = val[0];
      dsd_pkg::CfgStartHead: start_q = val;
      default: edge_q = val;
    endcase
    @(negedge clk_i);
  endtask

  // Send one request; idle first at random, then hold valid until accepted.
  // Valid stays high into the next request unless the sender idles, and drops after the last one.
  task automatic send_request(input logic [dsd_pkg::CylW-1:0] cyl, input logic last);
    if ($urandom_range(99) < sender_idle) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < sender_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{request_cylinder: cyl, last_request: last};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (last) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Let every prediction drain, then give the walker time to settle
  task automatic wait_drained();
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Random job: cylinders anywhere, up to the edge, near the start head or near the top
  task automatic random_job(input int len);
    logic [dsd_pkg::CylW-1:0] c;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: c = dsd_pkg::CylW'($urandom);
        1: c = dsd_pkg::CylW'($urandom_range(edge_q));
        2: c = dsd_pkg::CylW'(start_q + $urandom_range(8) - 4);
        default: c = dsd_pkg::CylW'($urandom_range(65535, 65520));
      endcase
      send_request(c, i == len - 1);
    end
  endtask

  typedef struct {
    logic [dsd_pkg::CylW-1:0] cyl;
    logic last;
    logic check;          // typed-in expectation present
    logic [dsd_pkg::SumW-1:0] move;
    logic [dsd_pkg::CntW-1:0] cnt;
  } row_t;

  // Directed rows under reset registers (FCFS from cylinder zero)
  row_t dir_rows[] = '{
    '{16'd0, 1'b1, 1'b1, 32'd0, 11'd1},
    '{16'hFFFF, 1'b1, 1'b1, 32'd65535, 11'd1},
    '{16'd100, 1'b0, 1'b0, 32'd0, 11'd0},
    '{16'd50, 1'b1, 1'b1, 32'd150, 11'd2},
    '{16'h5555, 1'b0, 1'b0, 32'd0, 11'd0},
    '{16'hAAAA, 1'b1, 1'b0, 32'd0, 11'd0}
  };

  initial begin
    int count;
    dsd_pkg::out_item_t got;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; typed-in expectations are checked on top of the predictor
    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].cyl, dir_rows[k].last);
      if (dir_rows[k].check) begin
        got = pending_q[$];
        if (got.total_movement !== dir_rows[k].move || got.request_count !== dir_rows[k].cnt)
          report_mismatch("directed row", k, k);
      end
    end
    wait_drained();

    // Every policy, both sweep directions, a few edge and head settings
    for (int p = 0; p < 8; p++) begin
      for (int dir = 0; dir < 2; dir++) begin
        write_reg(dsd_pkg::CfgPolicy, dsd_pkg::CfgDataW'(p));
        write_reg(dsd_pkg::CfgSweepDir, dsd_pkg::CfgDataW'(dir));
        write_reg(dsd_pkg::CfgStartHead, (p % 2) ? 16'hFFFF : 16'd2500);
        write_reg(dsd_pkg::CfgLastCyl, (dir) ? 16'd1 : 16'hFFFF);
        send_request(16'd0, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd2500, 1'b1);
        wait_drained();
      end
    end

    // Random jobs in three idling phases
    count = 0;
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle = (ph == 0) ? 6 : (ph == 1) ? 51 : 0;
      receiver_idle = (ph == 0) ? 51 : (ph == 1) ? 6 : 0;
      for (int j = 0; j < 30; j++) begin
        if (j % 5 == 0) begin
          wait_drained();
          write_reg(dsd_pkg::CfgPolicy, dsd_pkg::CfgDataW'($urandom_range(7)));
          write_reg(dsd_pkg::CfgSweepDir, dsd_pkg::CfgDataW'($urandom_range(1)));
          write_reg(dsd_pkg::CfgStartHead,
                    ($urandom_range(3) == 0) ? 16'hFFFF : dsd_pkg::CfgDataW'($urandom));
          write_reg(dsd_pkg::CfgLastCyl, ($urandom_range(3) == 0) ? 16'd1 :
                    dsd_pkg::CfgDataW'($urandom_range(65535, 1)));
        end
        random_job($urandom_range(10, 1));
      end
    end

    wait_drained();
    repeat (200) @(negedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
